### rtl/core/calorimeter_2x2_cluster_finder_core_macros.svh
`ifndef CALORIMETER_2X2_CLUSTER_FINDER_CORE_MACROS_SVH
`define CALORIMETER_2X2_CLUSTER_FINDER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define C2CF_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("c2cf: same-cycle check failed");

// next-cycle implication
`define C2CF_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("c2cf: next-cycle check failed");

`endif

### rtl/core/c2cf_pkg.sv
package c2cf_pkg;

  localparam int ETA_BINS = 12;
  localparam int PHI_BINS = 60;
  localparam int MAX_CL   = 64;
  localparam int NT       = ETA_BINS * PHI_BINS;
  localparam int TW       = $clog2(NT);
  localparam int EW       = $clog2(ETA_BINS);
  localparam int PW       = $clog2(PHI_BINS);
  localparam int CLW      = $clog2(MAX_CL + 1);
  localparam int NB       = 9;

  typedef logic [TW-1:0]  tidx_t;
  typedef logic [EW-1:0]  eidx_t;
  typedef logic [PW-1:0]  pidx_t;
  typedef logic [EW:0]    ewide_t;
  typedef logic [PW:0]    pwide_t;
  typedef logic [27:0]    en_t;
  typedef logic [29:0]    sum_t;
  typedef logic [CLW-1:0] ncl_t;

  localparam ncl_t CL_MAX = ncl_t'(MAX_CL);

  // neighbourhood slot (deta+1) + 3*(dphi+1) for quad q, position k, index {q,k}
  localparam logic [3:0] SLOT [16] = '{
    4'd4, 4'd7, 4'd5, 4'd8,
    4'd4, 4'd1, 4'd5, 4'd2,
    4'd4, 4'd1, 4'd3, 4'd0,
    4'd4, 4'd7, 4'd3, 4'd6
  };

  typedef struct packed {
    tidx_t       seed_index;
    logic [1:0]  quad;
    logic [3:0]  member_mask;
    logic [2:0]  tower_count;
    sum_t        energy_sum;
    logic        overflow;
    logic        last;
  } res_t;

endpackage

### rtl/core/c2cf_ram.sv
module c2cf_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/calorimeter_2x2_cluster_finder_core.sv
// 2x2 cluster finder over a 12 x 60 tower grid (index = eta + 12*phi).
// input channel (in_valid/in_ready): mode 0 loads one tower's energy and fail
// flag, one beat per cycle while idle; loads beyond the grid are dropped.
// mode 1 starts a run over the loaded grid and gives one beat per cluster on
// the output channel (out_valid/out_ready), the last one flagged by out_last,
// or a single all-zero beat with out_last for a run that finds nothing.
// a run walks the seeds in descending energy: finding each seed is one pass
// over the tower memory, then the 3x3 neighbourhood is fetched, the four
// quads are summed and the cluster is marked and queued; a seed already used
// or one that forms no cluster goes straight back to scanning. one more scan
// and the last beat end the run, then a clearing pass wipes energies, fail
// flags and used marks before in_ready rises again.
// reset (rst_n low, synchronous) restores the thresholds and runs the same
// clearing pass. cluster beats sit in a one-deep output register plus one
// held back to tag the last; a stalled receiver holds the run.
// config writes (cfg_we) are taken at any time but only while idle make sense.
module calorimeter_2x2_cluster_finder_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [27:0]            cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_mode,
  input  logic [9:0]             in_tower_index,
  input  logic [27:0]            in_energy,
  input  logic                   in_fail,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [9:0]             out_seed_index,
  output logic [1:0]             out_quad,
  output logic [3:0]             out_member_mask,
  output logic [2:0]             out_tower_count,
  output logic [29:0]            out_energy_sum,
  output logic                   out_overflow,
  output logic                   out_last
);

  `include "calorimeter_2x2_cluster_finder_core_macros.svh"

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLEAR  = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_FETCH  = 4'd3;
  localparam logic [3:0] S_EVAL   = 4'd4;
  localparam logic [3:0] S_PICK   = 4'd5;
  localparam logic [3:0] S_MARK   = 4'd6;
  localparam logic [3:0] S_PUSH   = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  localparam logic CFG_SEED   = 1'b0;
  localparam logic CFG_MEMBER = 1'b1;

  logic [3:0]       state_r;
  c2cf_pkg::en_t    seed_thr_r, mem_thr_r;
  c2cf_pkg::tidx_t  clr_r;

  // scan
  c2cf_pkg::tidx_t  a_r, d_idx_r, prev_idx_r, cand_idx_r, seed_idx_r;
  c2cf_pkg::eidx_t  a_eta_r, d_eta_r, cand_eta_r, seed_eta_r;
  c2cf_pkg::pidx_t  a_phi_r, d_phi_r, cand_phi_r, seed_phi_r;
  logic             a_done_r, d_v_r, d_last_r, prev_v_r, cand_v_r;
  c2cf_pkg::en_t    prev_e_r, cand_e_r;

  // neighbourhood
  logic [3:0]       j_r, jd_r;
  logic [1:0]       fe_r, fp_r;
  logic             jd_v_r, jd_eok_r, seed_used_r;
  c2cf_pkg::en_t    nb_e_r   [c2cf_pkg::NB];
  logic             nb_ok_r  [c2cf_pkg::NB];
  c2cf_pkg::tidx_t  nb_idx_r [c2cf_pkg::NB];

  // quad evaluation
  logic [3:0]       st_r;
  c2cf_pkg::sum_t   acc_r, qd_sum_r, best_sum_r;
  logic [3:0]       accm_r, qd_mask_r, best_mask_r;
  logic [2:0]       accc_r, qd_cnt_r, best_cnt_r;
  logic [1:0]       qd_q_r, best_q_r, mk_r;
  logic             qd_v_r;

  c2cf_pkg::ncl_t   n_r;
  logic             pend_v_r, ovf_r, out_v_r;
  c2cf_pkg::res_t   pend_r, out_r, new_res;

  // memories
  logic             e_we, u_we, u_wd, u_rd;
  c2cf_pkg::tidx_t  e_wa, u_wa, rd_addr;
  logic [28:0]      e_wd, e_rd;

  c2cf_ram #(.W(29), .DEPTH(c2cf_pkg::NT)) u_tower_ram (
    .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(rd_addr), .rdata(e_rd)
  );

  c2cf_ram #(.W(1), .DEPTH(c2cf_pkg::NT)) u_used_ram (
    .clk(clk), .we(u_we), .waddr(u_wa), .wdata(u_wd), .raddr(rd_addr), .rdata(u_rd)
  );

  logic in_acc, load_ok, out_free;
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign load_ok  = in_acc && !in_mode && (in_tower_index < c2cf_pkg::tidx_t'(c2cf_pkg::NT));
  assign out_free = !out_v_r || out_ready;

  // neighbourhood address, eta clipped, phi wrapped
  c2cf_pkg::ewide_t eta_w;
  c2cf_pkg::pwide_t phi_w, phi_m;
  c2cf_pkg::eidx_t  f_eta;
  c2cf_pkg::pidx_t  f_phi;
  c2cf_pkg::tidx_t  faddr;
  logic             f_eok;

  always_comb begin
    eta_w = {1'b0, seed_eta_r} + c2cf_pkg::ewide_t'(fe_r);
    f_eok = (eta_w != '0) && (eta_w <= c2cf_pkg::ewide_t'(c2cf_pkg::ETA_BINS));
    f_eta = c2cf_pkg::eidx_t'(eta_w - 1'b1);
    phi_w = {1'b0, seed_phi_r} + c2cf_pkg::pwide_t'(fp_r);
    phi_m = (phi_w == '0) ? c2cf_pkg::pwide_t'(c2cf_pkg::PHI_BINS - 1) : phi_w - 1'b1;
    f_phi = (phi_m == c2cf_pkg::pwide_t'(c2cf_pkg::PHI_BINS)) ? '0
                                                              : c2cf_pkg::pidx_t'(phi_m);
    faddr = c2cf_pkg::tidx_t'(f_eta)
          + c2cf_pkg::tidx_t'(c2cf_pkg::ETA_BINS) * c2cf_pkg::tidx_t'(f_phi);
  end

  assign rd_addr = (state_r == S_SCAN) ? a_r : faddr;

  // scan compare: next seed must rank strictly after the previous one
  c2cf_pkg::en_t d_e;
  logic          d_qual, d_take;
  assign d_e    = e_rd[27:0];
  assign d_qual = !e_rd[28] && (d_e > seed_thr_r) &&
                  (!prev_v_r || (d_e < prev_e_r) || ((d_e == prev_e_r) && (d_idx_r > prev_idx_r)));
  assign d_take = d_v_r && d_qual && (!cand_v_r || (d_e > cand_e_r));

  // quad accumulation
  logic [3:0]      ev_slot, mk_slot;
  logic            ev_ok;
  c2cf_pkg::sum_t  sum_n;
  logic [3:0]      mask_n;
  logic [2:0]      cnt_n;
  logic            best_upd;
  logic [2:0]      best_cnt_n;

  always_comb begin
    ev_slot    = c2cf_pkg::SLOT[st_r];
    mk_slot    = c2cf_pkg::SLOT[{best_q_r, mk_r}];
    ev_ok      = nb_ok_r[ev_slot];
    sum_n      = acc_r + (ev_ok ? c2cf_pkg::sum_t'(nb_e_r[ev_slot]) : '0);
    mask_n     = accm_r | (ev_ok ? (4'b0001 << st_r[1:0]) : 4'b0000);
    cnt_n      = accc_r + 3'(ev_ok);
    best_upd   = qd_v_r && (qd_cnt_r != '0) && (qd_sum_r > best_sum_r);
    best_cnt_n = best_upd ? qd_cnt_r : best_cnt_r;
  end

  always_comb begin
    new_res             = '0;
    new_res.seed_index  = seed_idx_r;
    new_res.quad        = best_q_r;
    new_res.member_mask = best_mask_r;
    new_res.tower_count = best_cnt_r;
    new_res.energy_sum  = best_sum_r;
  end

  always_comb begin
    e_we = load_ok || (state_r == S_CLEAR);
    e_wa = (state_r == S_CLEAR) ? clr_r : in_tower_index;
    e_wd = (state_r == S_CLEAR) ? '0 : {in_fail, in_energy};
    u_we = ((state_r == S_MARK) && best_mask_r[mk_r]) || (state_r == S_CLEAR);
    u_wa = (state_r == S_CLEAR) ? clr_r : nb_idx_r[mk_slot];
    u_wd = (state_r != S_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      seed_thr_r <= c2cf_pkg::en_t'(800000);
      mem_thr_r  <= c2cf_pkg::en_t'(100000);
      out_v_r    <= 1'b0;
      pend_v_r   <= 1'b0;
      n_r        <= '0;
      ovf_r      <= 1'b0;
      prev_v_r   <= 1'b0;
      cand_v_r   <= 1'b0;
      a_done_r   <= 1'b0;
      d_v_r      <= 1'b0;
      jd_v_r     <= 1'b0;
      qd_v_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SEED:   seed_thr_r <= cfg_wdata;
          CFG_MEMBER: mem_thr_r  <= cfg_wdata;
          default:    ;
        endcase
      end
      if (out_v_r && out_ready) begin
        out_v_r <= 1'b0;
      end

      unique case (state_r) inside
        S_IDLE: begin
          if (in_acc && in_mode) begin
            n_r      <= '0;
            ovf_r    <= 1'b0;
            pend_v_r <= 1'b0;
            prev_v_r <= 1'b0;
            a_r      <= '0;
            a_eta_r  <= '0;
            a_phi_r  <= '0;
            a_done_r <= 1'b0;
            d_v_r    <= 1'b0;
            cand_v_r <= 1'b0;
            state_r  <= S_SCAN;
          end
        end

        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == c2cf_pkg::tidx_t'(c2cf_pkg::NT - 1)) begin
            clr_r   <= '0;
            state_r <= S_IDLE;
          end
        end

        S_SCAN: begin
          d_v_r    <= !a_done_r;
          d_last_r <= (a_r == c2cf_pkg::tidx_t'(c2cf_pkg::NT - 1));
          d_idx_r  <= a_r;
          d_eta_r  <= a_eta_r;
          d_phi_r  <= a_phi_r;
          if (!a_done_r) begin
            a_r <= a_r + 1'b1;
            if (a_r == c2cf_pkg::tidx_t'(c2cf_pkg::NT - 1)) begin
              a_done_r <= 1'b1;
            end
            if (a_eta_r == c2cf_pkg::eidx_t'(c2cf_pkg::ETA_BINS - 1)) begin
              a_eta_r <= '0;
              a_phi_r <= a_phi_r + 1'b1;
            end else begin
              a_eta_r <= a_eta_r + 1'b1;
            end
          end
          if (d_take) begin
            cand_v_r   <= 1'b1;
            cand_e_r   <= d_e;
            cand_idx_r <= d_idx_r;
            cand_eta_r <= d_eta_r;
            cand_phi_r <= d_phi_r;
          end
          if (d_v_r && d_last_r) begin
            d_v_r <= 1'b0;
            if (d_take || cand_v_r) begin
              seed_idx_r <= d_take ? d_idx_r : cand_idx_r;
              seed_eta_r <= d_take ? d_eta_r : cand_eta_r;
              seed_phi_r <= d_take ? d_phi_r : cand_phi_r;
              prev_v_r   <= 1'b1;
              prev_e_r   <= d_take ? d_e : cand_e_r;
              prev_idx_r <= d_take ? d_idx_r : cand_idx_r;
              j_r        <= '0;
              fe_r       <= '0;
              fp_r       <= '0;
              jd_v_r     <= 1'b0;
              state_r    <= S_FETCH;
            end else begin
              state_r <= S_FINISH;
            end
          end
        end

        S_FETCH: begin
          jd_v_r   <= (j_r != 4'(c2cf_pkg::NB));
          jd_r     <= j_r;
          jd_eok_r <= f_eok;
          if (j_r != 4'(c2cf_pkg::NB)) begin
            nb_idx_r[j_r] <= faddr;
            j_r           <= j_r + 1'b1;
            if (fe_r == 2'd2) begin
              fe_r <= '0;
              fp_r <= fp_r + 1'b1;
            end else begin
              fe_r <= fe_r + 1'b1;
            end
          end
          if (jd_v_r) begin
            nb_e_r[jd_r]  <= e_rd[27:0];
            nb_ok_r[jd_r] <= jd_eok_r && !u_rd && (e_rd[27:0] > mem_thr_r);
            if (jd_r == 4'd4) begin
              seed_used_r <= u_rd;
            end
            if (jd_r == 4'(c2cf_pkg::NB - 1)) begin
              jd_v_r <= 1'b0;
              if (seed_used_r) begin
                a_r      <= '0;
                a_eta_r  <= '0;
                a_phi_r  <= '0;
                a_done_r <= 1'b0;
                cand_v_r <= 1'b0;
                state_r  <= S_SCAN;
              end else begin
                st_r        <= '0;
                acc_r       <= '0;
                accm_r      <= '0;
                accc_r      <= '0;
                qd_v_r      <= 1'b0;
                best_sum_r  <= '0;
                best_mask_r <= '0;
                best_cnt_r  <= '0;
                best_q_r    <= '0;
                state_r     <= S_EVAL;
              end
            end
          end
        end

        S_EVAL, S_PICK: begin
          // the quad that finished last cycle competes while the next one sums
          if (best_upd) begin
            best_sum_r  <= qd_sum_r;
            best_mask_r <= qd_mask_r;
            best_cnt_r  <= qd_cnt_r;
            best_q_r    <= qd_q_r;
          end
          qd_v_r <= 1'b0;
          if (state_r == S_EVAL) begin
            st_r <= st_r + 1'b1;
            if (st_r[1:0] == 2'd3) begin
              qd_v_r    <= 1'b1;
              qd_sum_r  <= sum_n;
              qd_mask_r <= mask_n;
              qd_cnt_r  <= cnt_n;
              qd_q_r    <= st_r[3:2];
              acc_r     <= '0;
              accm_r    <= '0;
              accc_r    <= '0;
            end else begin
              acc_r  <= sum_n;
              accm_r <= mask_n;
              accc_r <= cnt_n;
            end
            if (st_r == 4'd15) begin
              state_r <= S_PICK;
            end
          end else if (best_cnt_n == '0) begin
            a_r      <= '0;
            a_eta_r  <= '0;
            a_phi_r  <= '0;
            a_done_r <= 1'b0;
            cand_v_r <= 1'b0;
            state_r  <= S_SCAN;
          end else if (n_r == c2cf_pkg::CL_MAX) begin
            ovf_r   <= 1'b1;
            state_r <= S_FINISH;
          end else begin
            mk_r    <= '0;
            state_r <= S_MARK;
          end
        end

        S_MARK: begin
          mk_r <= mk_r + 1'b1;
          if (mk_r == 2'd3) begin
            state_r <= S_PUSH;
          end
        end

        S_PUSH: begin
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              out_r   <= pend_r;
              out_v_r <= 1'b1;
            end
            pend_r   <= new_res;
            pend_v_r <= 1'b1;
            n_r      <= n_r + 1'b1;
            a_r      <= '0;
            a_eta_r  <= '0;
            a_phi_r  <= '0;
            a_done_r <= 1'b0;
            cand_v_r <= 1'b0;
            state_r  <= S_SCAN;
          end
        end

        S_FINISH: begin
          if (out_free) begin
            out_r          <= pend_v_r ? pend_r : '0;
            out_r.overflow <= pend_v_r && ovf_r;
            out_r.last     <= 1'b1;
            out_v_r        <= 1'b1;
            pend_v_r       <= 1'b0;
            clr_r          <= '0;
            state_r        <= S_CLEAR;
          end
        end

        default: state_r <= S_CLEAR;
      endcase
    end
  end

  assign out_valid       = out_v_r;
  assign out_seed_index  = out_r.seed_index;
  assign out_quad        = out_r.quad;
  assign out_member_mask = out_r.member_mask;
  assign out_tower_count = out_r.tower_count;
  assign out_energy_sum  = out_r.energy_sum;
  assign out_overflow    = out_r.overflow;
  assign out_last        = out_r.last;

  `C2CF_ASSERT_IMP(a_ncl_cap, 1'b1, n_r <= c2cf_pkg::CL_MAX)
  `C2CF_ASSERT_IMP(a_best_cnt, state_r == S_MARK, best_cnt_r == 3'($countones(best_mask_r)))
  `C2CF_ASSERT_NEXT(a_run_end, (state_r == S_FINISH) && out_free, state_r == S_CLEAR)
  `C2CF_ASSERT_IMP(a_idle_clean, in_ready, !pend_v_r)

endmodule
